[hdl/fac_pkg.sv]
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants for the frustum box culling pipeline.
// ----------------------------------------------------------------------------
package fac_pkg;

    // Configuration port geometry.
    localparam int PLANE_REGS = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Fraction bits of the Q2.14 normal; the distance is scaled to match.
    localparam int NORM_FRAC  = 14;

    // Register stages inside one plane evaluator.
    localparam int EVAL_LAT   = 3;

    // One plane word as written on the configuration port.
    typedef struct packed {
        logic signed [15:0] d;
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
    } plane_t;

endpackage

[hdl/fac_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fac_cfg_regs
// Plane register file, written through the plain configuration write port.
// ----------------------------------------------------------------------------
module fac_cfg_regs
    import fac_pkg::*;
#(
    parameter int NUM_ACT = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output plane_t                planes [NUM_ACT]
);

    plane_t plane_reg [NUM_ACT];

    // Each active plane takes the word whose index matches; other indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ACT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < NUM_ACT; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    plane_reg[i] <= plane_t'(cfg_data);
                end
            end
        end
    end

    assign planes = plane_reg;

endmodule

[hdl/fac_plane_eval.sv]
// ----------------------------------------------------------------------------
// fac_plane_eval
// Three-stage test of one box against one plane. The largest plane value over
// the eight corners is the distance plus, per axis, the larger of the two
// products, so the box is culled when that sum is not above zero.
// ----------------------------------------------------------------------------
module fac_plane_eval
    import fac_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  plane_t                       plane,
    input  logic signed [COORD_BITS-1:0] box_lo [3],
    input  logic signed [COORD_BITS-1:0] box_hi [3],
    output logic                         culled
);

    localparam int PROD_W = 16 + COORD_BITS;
    localparam int DIST_W = 16 + NORM_FRAC;
    localparam int SUM_W  = ((PROD_W > DIST_W) ? PROD_W : DIST_W) + 2;

    logic signed [15:0]       norm [3];
    logic signed [PROD_W-1:0] prod_lo_reg [3];
    logic signed [PROD_W-1:0] prod_hi_reg [3];
    logic signed [PROD_W-1:0] max_reg [3];
    logic signed [SUM_W-1:0]  sum_next;
    logic                     culled_reg;

    assign norm[0] = plane.nx;
    assign norm[1] = plane.ny;
    assign norm[2] = plane.nz;

    // Stage A: normal times both box extents on every axis.
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            prod_lo_reg[a] <= PROD_W'(norm[a]) * PROD_W'(box_lo[a]);
            prod_hi_reg[a] <= PROD_W'(norm[a]) * PROD_W'(box_hi[a]);
        end
    end

    // Stage B: keep the larger product, the corner that lies furthest in front.
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            max_reg[a] <= (prod_hi_reg[a] > prod_lo_reg[a]) ? prod_hi_reg[a]
                                                            : prod_lo_reg[a];
        end
    end

    // Stage C: add the scaled distance and test for a strictly positive sum.
    always_comb
    begin
        sum_next = SUM_W'(max_reg[0]) + SUM_W'(max_reg[1]) + SUM_W'(max_reg[2])
                 + (SUM_W'(plane.d) <<< NORM_FRAC);
    end

    always_ff @(posedge clk)
    begin
        culled_reg <= sum_next[SUM_W-1] || (sum_next == '0);
    end

    assign culled = culled_reg;

endmodule

[hdl/frustum_aabb_cull.sv]
// ----------------------------------------------------------------------------
// frustum_aabb_cull
// View-frustum culling of axis-aligned boxes against up to six planes.
//
//   channel   handshake             word
//   -------   -------------------   ---------------------------------------
//   box in    start, busy           min_x min_y min_z max_x max_y max_z
//   result    done (one cycle)      visible
//   config    cfg_we                cfg_index, cfg_data (one plane word)
//
// One box is taken in every cycle; busy is always low. Each box goes through
// the input register, three stages of the plane evaluators (multiply,
// per-axis max, sum and sign test) and the output register to its result.
// The receiver cannot stall, so the pipeline never holds. Reset clears the
// valid line and the plane registers; zero planes cull every box.
// ----------------------------------------------------------------------------
module frustum_aabb_cull
    import fac_pkg::*;
#(
    parameter int NUM_PLANES = 6,
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] min_x,
    input  logic signed [COORD_BITS-1:0] min_y,
    input  logic signed [COORD_BITS-1:0] min_z,
    input  logic signed [COORD_BITS-1:0] max_x,
    input  logic signed [COORD_BITS-1:0] max_y,
    input  logic signed [COORD_BITS-1:0] max_z,
    output logic                         done,
    output logic                         visible,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int NUM_ACT = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;
    localparam int LAST    = EVAL_LAT + 1;

    logic                         accept;
    logic [LAST:0]                valid_reg;
    logic signed [COORD_BITS-1:0] box_lo_reg [3];
    logic signed [COORD_BITS-1:0] box_hi_reg [3];
    logic [NUM_ACT-1:0]           culled;
    logic                         visible_reg;
    plane_t                       planes [NUM_ACT];

    // The pipeline never holds, so a box is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid line that follows each word down the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAST-1:0], accept};
        end
    end

    // Input register for the box corners.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            box_lo_reg[0] <= min_x;
            box_lo_reg[1] <= min_y;
            box_lo_reg[2] <= min_z;
            box_hi_reg[0] <= max_x;
            box_hi_reg[1] <= max_y;
            box_hi_reg[2] <= max_z;
        end
    end

    fac_cfg_regs #(
        .NUM_ACT (NUM_ACT)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    // One evaluator per active plane, all working on the same box.
    for (genvar p = 0; p < NUM_ACT; p++)
    begin : g_plane
        fac_plane_eval #(
            .COORD_BITS (COORD_BITS)
        ) u_plane_eval (
            .clk    (clk),
            .plane  (planes[p]),
            .box_lo (box_lo_reg),
            .box_hi (box_hi_reg),
            .culled (culled[p])
        );
    end

    // Output register: visible when no plane culls the box.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visible_reg <= 1'b0;
        end
        else if (valid_reg[EVAL_LAT])
        begin
            visible_reg <= ~|culled;
        end
    end

    assign done    = valid_reg[LAST];
    assign visible = visible_reg;

    // Every accepted box yields its result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LAST + 1) done)
        else $error("accepted box produced no result at the expected cycle");

    // No result without a box accepted at the matching earlier cycle.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAST + 1))
        else $error("result strobe without a matching accepted box");

    // The result bit moves only when a new result is loaded.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[EVAL_LAT] |=> $stable(visible))
        else $error("visible changed without a new result");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frustum box culling pipeline. Box words are
// sent with random gaps, and the plane registers are loaded between phases.
// A behavioral predictor works out the visibility of each box, and each
// result strobe is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import fac_pkg::*;

    // One box word: minimum and maximum corner.
    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] min_y;
        logic signed [15:0] min_z;
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
        logic signed [15:0] max_z;
    } box_t;

    // A normal of length one in Q2.14.
    localparam int UNIT_NORMAL = 1 << NORM_FRAC;
    localparam int PIPE_DRAIN  = 10;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     start     = 1'b0;
    logic signed [15:0]       min_x     = '0;
    logic signed [15:0]       min_y     = '0;
    logic signed [15:0]       min_z     = '0;
    logic signed [15:0]       max_x     = '0;
    logic signed [15:0]       max_y     = '0;
    logic signed [15:0]       max_z     = '0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;
    logic                     busy;
    logic                     done;
    logic                     visible;

    // Local copy of the plane registers, cleared as by reset.
    plane_t frustum_planes [PLANE_REGS] = '{default: '0};
    bit     visibility_queue [$];
    bit     steady_stream = 1'b0;
    int     fail_count    = 0;

    frustum_aabb_cull dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .min_x     (min_x),
        .min_y     (min_y),
        .min_z     (min_z),
        .max_x     (max_x),
        .max_y     (max_y),
        .max_z     (max_z),
        .done      (done),
        .visible   (visible),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Largest product of one normal component over the two box extents.
    function automatic longint farthest_term(logic signed [15:0] n,
                                             logic signed [15:0] a,
                                             logic signed [15:0] b);
        longint pa;
        longint pb;
        pa = longint'(n) * longint'(a);
        pb = longint'(n) * longint'(b);
        return (pa > pb) ? pa : pb;
    endfunction

    // The axes are independent, so the best corner is the per-axis maximum.
    // The plane rejects the box when even that corner is on or behind it.
    function automatic bit plane_rejects(plane_t p, box_t b);
        longint reach;
        reach = longint'(p.d) * (longint'(1) << NORM_FRAC);
        reach += farthest_term(p.nx, b.min_x, b.max_x);
        reach += farthest_term(p.ny, b.min_y, b.max_y);
        reach += farthest_term(p.nz, b.min_z, b.max_z);
        return reach <= 0;
    endfunction

    function automatic bit predict_visibility(box_t b);
        for (int i = 0; i < PLANE_REGS; i++)
        begin
            if (plane_rejects(frustum_planes[i], b))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Put one box word on the ports and hold it until it is taken.
    task automatic send_box(box_t b);
        start <= 1'b1;
        min_x <= b.min_x;
        min_y <= b.min_y;
        min_z <= b.min_z;
        max_x <= b.max_x;
        max_y <= b.max_y;
        max_z <= b.max_z;
        do
            @(posedge clk);
        while (busy);
        visibility_queue.push_back(predict_visibility(b));
    endtask

    // Random sender gaps, none while a steady stream is wanted.
    task automatic maybe_pause();
        if (!steady_stream && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic settle();
        start <= 1'b0;
        while (visibility_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // Write enable is left high so that writes can follow back to back.
    task automatic write_plane(int idx, plane_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= value;
        @(posedge clk);
        if (idx < PLANE_REGS)
            frustum_planes[idx] = value;
    endtask

    task automatic close_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic signed [15:0] to_coord(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic box_t box_of(int x0, int y0, int z0, int x1, int y1, int z1);
        box_t b;
        b.min_x = to_coord(x0);
        b.min_y = to_coord(y0);
        b.min_z = to_coord(z0);
        b.max_x = to_coord(x1);
        b.max_y = to_coord(y1);
        b.max_z = to_coord(z1);
        return b;
    endfunction

    // Plane facing along one axis; plane index 2k faces +axis k, 2k+1 faces -axis k.
    function automatic plane_t axis_plane(int axis, bit toward_pos, int reach);
        int     comp [3];
        plane_t p;
        comp = '{0, 0, 0};
        comp[axis] = toward_pos ? UNIT_NORMAL : -UNIT_NORMAL;
        p.nx = 16'(comp[0]);
        p.ny = 16'(comp[1]);
        p.nz = 16'(comp[2]);
        p.d  = 16'(reach);
        return p;
    endfunction

    // Axis plane with its normal tipped at random.
    function automatic plane_t tilted_plane(int axis, bit toward_pos, int reach);
        int     comp [3];
        plane_t p;
        for (int a = 0; a < 3; a++)
            comp[a] = int'($urandom_range(6000)) - 3000;
        comp[axis] = UNIT_NORMAL - int'($urandom_range(3000));
        if (!toward_pos)
            comp[axis] = -comp[axis];
        p.nx = 16'(comp[0]);
        p.ny = 16'(comp[1]);
        p.nz = 16'(comp[2]);
        p.d  = 16'(reach);
        return p;
    endfunction

    // Mostly small boxes around a frustum of half width reach; some pure noise.
    function automatic box_t random_box(int reach);
        box_t b;
        int   lo [3];
        int   hi [3];
        int   mid;
        int   half;
        if ($urandom_range(99) < 15)
        begin
            b = {$urandom, $urandom, $urandom};
            return b;
        end
        for (int a = 0; a < 3; a++)
        begin
            mid   = int'($urandom_range(3 * reach)) - (3 * reach) / 2;
            half  = int'($urandom_range(reach / 3));
            lo[a] = mid - half;
            hi[a] = mid + half;
        end
        if ($urandom_range(99) < 5)
            b = box_of(hi[0], hi[1], hi[2], lo[0], lo[1], lo[2]);
        else
            b = box_of(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero planes after reset reject every box.
    task automatic test_reset_cull();
        send_box(box_of(-10, -10, -10, 10, 10, 10));
        maybe_pause();
        send_box(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(box_of(5, 5, 5, 5, 5, 5));
        settle();
    endtask

    // Most negative and most positive plane words against extreme boxes.
    task automatic test_extreme_words();
        plane_t words [2];
        words[0] = plane_t'(64'h8000_8000_8000_8000);
        words[1] = plane_t'(64'h7fff_7fff_7fff_7fff);
        foreach (words[w])
        begin
            for (int i = 0; i < PLANE_REGS; i++)
                write_plane(i, words[w]);
            close_writes();
            send_box(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
            send_box(box_of(-32768, -32768, -32768, -32768, -32768, -32768));
            maybe_pause();
            send_box(box_of(32767, 32767, 32767, 32767, 32767, 32767));
            settle();
        end
    endtask

    // A cube of half width 1000: inside, outside each face, straddling,
    // exactly touching a face, and inverted boxes.
    task automatic test_frustum_boundaries();
        for (int i = 0; i < PLANE_REGS; i++)
            write_plane(i, axis_plane(i / 2, (i % 2) == 0, 1000));
        close_writes();
        send_box(box_of(-10, -10, -10, 10, 10, 10));
        send_box(box_of(-3000, -10, -10, -2000, 10, 10));
        send_box(box_of(2000, -10, -10, 3000, 10, 10));
        maybe_pause();
        send_box(box_of(-10, -3000, -10, 10, -2000, 10));
        send_box(box_of(-10, 2000, -10, 10, 3000, 10));
        send_box(box_of(-10, -10, -3000, 10, 10, -2000));
        send_box(box_of(-10, -10, 2000, 10, 10, 3000));
        maybe_pause();
        send_box(box_of(-1500, -10, -10, -500, 10, 10));
        send_box(box_of(-2000, -10, -10, -1000, 10, 10));
        send_box(box_of(500, 10, 10, -500, -10, -10));
        send_box(box_of(-500, -10, -10, -2000, 10, 10));
        settle();
    endtask

    // Writes to indexes past the plane list must not touch any plane.
    task automatic test_ignored_index();
        write_plane(PLANE_REGS, '0);
        write_plane(PLANE_REGS + 1, '0);
        close_writes();
        send_box(box_of(-10, -10, -10, 10, 10, 10));
        send_box(box_of(-900, -900, -900, 900, 900, 900));
        settle();
    endtask

    // Random tilted frusta of random size, one of them streamed without gaps.
    task automatic test_random_frusta();
        int reach;
        for (int phase = 0; phase < 5; phase++)
        begin
            reach = $urandom_range(20000, 200);
            if (phase == 4)
                reach = 32767;
            for (int i = 0; i < PLANE_REGS; i++)
                write_plane(i, tilted_plane(i / 2, (i % 2) == 0, reach));
            close_writes();
            steady_stream = (phase == 2);
            for (int n = 0; n < 110; n++)
            begin
                maybe_pause();
                send_box(random_box(reach));
            end
            settle();
        end
        steady_stream = 1'b0;
    endtask

    // Fully random plane words, mostly with a positive distance.
    task automatic test_random_plane_words();
        plane_t p;
        for (int phase = 0; phase < 2; phase++)
        begin
            for (int i = 0; i < PLANE_REGS; i++)
            begin
                p = {$urandom, $urandom};
                if ($urandom_range(3) != 0)
                    p.d[15] = 1'b0;
                write_plane(i, p);
            end
            close_writes();
            for (int n = 0; n < 60; n++)
            begin
                maybe_pause();
                send_box(random_box($urandom_range(30000, 100)));
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking: every strobe is matched to the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit predicted;
        if (rst_n && done)
        begin
            if (visibility_queue.size() == 0)
            begin
                $error("visible: result with no box waiting, actual %0b", visible);
                fail_count++;
            end
            else
            begin
                predicted = visibility_queue.pop_front();
                if (visible !== predicted)
                begin
                    $error("visible: expected %0b, actual %0b", predicted, visible);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_cull();
        test_extreme_words();
        test_frustum_boundaries();
        test_ignored_index();
        test_random_frusta();
        test_random_plane_words();
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Hard stop in case the pipeline hangs.
    initial
    begin
        #3_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/fac_pkg.sv
hdl/fac_cfg_regs.sv
hdl/fac_plane_eval.sv
hdl/frustum_aabb_cull.sv
dv/testbench.sv
